FILE: rtl/c8alu_pkg.sv
package c8alu_pkg;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_ADC  = 5'd1,
		OP_SUB  = 5'd2,
		OP_SBC  = 5'd3,
		OP_AND  = 5'd4,
		OP_XOR  = 5'd5,
		OP_OR   = 5'd6,
		OP_CP   = 5'd7,
		OP_INC  = 5'd8,
		OP_DEC  = 5'd9,
		OP_DAA  = 5'd10,
		OP_CPL  = 5'd11,
		OP_RLC  = 5'd12,
		OP_RL   = 5'd13,
		OP_RRC  = 5'd14,
		OP_RR   = 5'd15,
		OP_SLA  = 5'd16,
		OP_SRA  = 5'd17,
		OP_SRL  = 5'd18,
		OP_SWAP = 5'd19,
		OP_BIT  = 5'd20,
		OP_RES  = 5'd21,
		OP_SET  = 5'd22,
		OP_CCF  = 5'd23,
		OP_SCF  = 5'd24,
		OP_RLCA = 5'd25,
		OP_RLA  = 5'd26,
		OP_RRCA = 5'd27,
		OP_RRA  = 5'd28
	} op_t;

	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	typedef struct packed {
		logic [7:0] result;
		logic [3:0] flags;
		logic       write_back;
	} alu_res_t;

endpackage

FILE: rtl/cpu_8bit_alu_with_flags_unit.sv
// An accepted request is captured in the stage-1 registers; its result is registered in stage 2 and drives the ports.
// Throughput: one request per cycle; busy is always low.
// done marks the result on the ports for one cycle; the receiver cannot stall.
// Reset clears the stage valid bits, so done stays low until a new request arrives.
module cpu_8bit_alu_with_flags_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [4:0] action,
	input  logic [7:0] accumulator,
	input  logic [7:0] operand,
	input  logic [2:0] bit_index,
	input  logic [3:0] flags_in,
	output logic       done,
	output logic [7:0] result,
	output logic [3:0] flags_out,
	output logic       write_back
);
	import c8alu_pkg::*;

	logic       valid_s1, valid_s2;
	logic [4:0] action_s1;
	logic [7:0] accumulator_s1, operand_s1;
	logic [2:0] bit_index_s1;
	logic [3:0] flags_s1;
	alu_res_t   res_comb, res_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			action_s1 <= action;
			accumulator_s1 <= accumulator;
			operand_s1 <= operand;
			bit_index_s1 <= bit_index;
			flags_s1 <= flags_in;
		end
		if (valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	c8alu_exec u_exec (
		.action      (action_s1),
		.accumulator (accumulator_s1),
		.operand     (operand_s1),
		.bit_index   (bit_index_s1),
		.flags_in    (flags_s1),
		.res         (res_comb)
	);

	assign done       = valid_s2;
	assign result     = res_s2.result;
	assign flags_out  = res_s2.flags;
	assign write_back = res_s2.write_back;

endmodule

FILE: rtl/c8alu_exec.sv
module c8alu_exec (
	input  logic [4:0]          action,
	input  logic [7:0]          accumulator,
	input  logic [7:0]          operand,
	input  logic [2:0]          bit_index,
	input  logic [3:0]          flags_in,
	output c8alu_pkg::alu_res_t res
);
	import c8alu_pkg::*;

	logic       fz, fn, fh, fc;
	logic       cin_add, cin_sub;
	logic [8:0] sum9, diff9;
	logic [4:0] hsum, hdiff;
	logic [7:0] daa_adj, daa_r;
	logic       daa_c;
	logic [7:0] mask;

	assign fz = flags_in[FLAG_Z];
	assign fn = flags_in[FLAG_N];
	assign fh = flags_in[FLAG_H];
	assign fc = flags_in[FLAG_C];

	assign cin_add = (action == OP_ADC) ? fc : 1'b0;
	assign cin_sub = (action == OP_SBC) ? fc : 1'b0;
	assign sum9  = {1'b0, accumulator} + {1'b0, operand} + {8'd0, cin_add};
	assign hsum  = {1'b0, accumulator[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin_add};
	assign diff9 = {1'b0, accumulator} - {1'b0, operand} - {8'd0, cin_sub};
	assign hdiff = {1'b0, accumulator[3:0]} - {1'b0, operand[3:0]} - {4'd0, cin_sub};
	assign mask  = 8'd1 << bit_index;

	always_comb begin
		daa_adj = 8'd0;
		daa_c = fc;
		if (!fn) begin
			if (fc || accumulator > 8'h99) begin
				daa_adj = daa_adj | 8'h60;
				daa_c = 1'b1;
			end
			if (fh || accumulator[3:0] > 4'h9) begin
				daa_adj = daa_adj | 8'h06;
			end
			daa_r = accumulator + daa_adj;
		end else begin
			if (fc) begin
				daa_adj = daa_adj | 8'h60;
			end
			if (fh) begin
				daa_adj = daa_adj | 8'h06;
			end
			daa_r = accumulator - daa_adj;
		end
	end

	always_comb begin
		res.result = accumulator;
		res.flags = flags_in;
		res.write_back = 1'b1;
		unique case (op_t'(action))
			OP_ADD, OP_ADC: begin
				res.result = sum9[7:0];
				res.flags = {sum9[7:0] == 8'd0, 1'b0, hsum[4], sum9[8]};
			end
			OP_SUB, OP_SBC: begin
				res.result = diff9[7:0];
				res.flags = {diff9[7:0] == 8'd0, 1'b1, hdiff[4], diff9[8]};
			end
			OP_CP: begin
				res.flags = {diff9[7:0] == 8'd0, 1'b1, hdiff[4], diff9[8]};
				res.write_back = 1'b0;
			end
			OP_AND: begin
				res.result = accumulator & operand;
				res.flags = {(accumulator & operand) == 8'd0, 1'b0, 1'b1, 1'b0};
			end
			OP_XOR: begin
				res.result = accumulator ^ operand;
				res.flags = {(accumulator ^ operand) == 8'd0, 3'b000};
			end
			OP_OR: begin
				res.result = accumulator | operand;
				res.flags = {(accumulator | operand) == 8'd0, 3'b000};
			end
			OP_INC: begin
				res.result = operand + 8'd1;
				res.flags = {operand == 8'hff, 1'b0, operand[3:0] == 4'hf, fc};
			end
			OP_DEC: begin
				res.result = operand - 8'd1;
				res.flags = {operand == 8'h01, 1'b1, operand[3:0] == 4'h0, fc};
			end
			OP_DAA: begin
				res.result = daa_r;
				res.flags = {daa_r == 8'd0, fn, 1'b0, daa_c};
			end
			OP_CPL: begin
				res.result = ~accumulator;
				res.flags = {fz, 1'b1, 1'b1, fc};
			end
			OP_RLC: begin
				res.result = {operand[6:0], operand[7]};
				res.flags = {operand == 8'd0, 2'b00, operand[7]};
			end
			OP_RL: begin
				res.result = {operand[6:0], fc};
				res.flags = {{operand[6:0], fc} == 8'd0, 2'b00, operand[7]};
			end
			OP_SLA: begin
				res.result = {operand[6:0], 1'b0};
				res.flags = {operand[6:0] == 7'd0, 2'b00, operand[7]};
			end
			OP_RRC: begin
				res.result = {operand[0], operand[7:1]};
				res.flags = {operand == 8'd0, 2'b00, operand[0]};
			end
			OP_RR: begin
				res.result = {fc, operand[7:1]};
				res.flags = {{fc, operand[7:1]} == 8'd0, 2'b00, operand[0]};
			end
			OP_SRA: begin
				res.result = {operand[7], operand[7:1]};
				res.flags = {operand[7:1] == 7'd0, 2'b00, operand[0]};
			end
			OP_SRL: begin
				res.result = {1'b0, operand[7:1]};
				res.flags = {operand[7:1] == 7'd0, 2'b00, operand[0]};
			end
			OP_SWAP: begin
				res.result = {operand[3:0], operand[7:4]};
				res.flags = {operand == 8'd0, 3'b000};
			end
			OP_BIT: begin
				res.result = operand;
				res.flags = {(operand & mask) == 8'd0, 1'b0, 1'b1, fc};
				res.write_back = 1'b0;
			end
			OP_RES: begin
				res.result = operand & ~mask;
			end
			OP_SET: begin
				res.result = operand | mask;
			end
			OP_CCF: begin
				res.flags = {fz, 1'b0, 1'b0, ~fc};
				res.write_back = 1'b0;
			end
			OP_SCF: begin
				res.flags = {fz, 1'b0, 1'b0, 1'b1};
				res.write_back = 1'b0;
			end
			OP_RLCA: begin
				res.result = {accumulator[6:0], accumulator[7]};
				res.flags = {3'b000, accumulator[7]};
			end
			OP_RLA: begin
				res.result = {accumulator[6:0], fc};
				res.flags = {3'b000, accumulator[7]};
			end
			OP_RRCA: begin
				res.result = {accumulator[0], accumulator[7:1]};
				res.flags = {3'b000, accumulator[0]};
			end
			OP_RRA: begin
				res.result = {fc, accumulator[7:1]};
				res.flags = {3'b000, accumulator[0]};
			end
			default: begin
				res.write_back = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/c8alu_checker.sv
module c8alu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [4:0] action,
	input logic [7:0] accumulator,
	input logic [3:0] flags_in,
	input logic       done,
	input logic [7:0] result,
	input logic [3:0] flags_out,
	input logic       write_back
);
	import c8alu_pkg::*;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted request gave no result two cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without a matching request");

	a_cp_keeps_a: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(action, 2) == OP_CP) |->
		(!write_back && result == $past(accumulator, 2) && flags_out[FLAG_N]))
		else $error("compare altered the accumulator or missed the subtract flag");

	a_scf: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(action, 2) == OP_SCF) |->
		(flags_out[FLAG_C] && !write_back && flags_out[FLAG_Z] == $past(flags_in[FLAG_Z], 2)))
		else $error("set carry flag produced wrong flags");

endmodule

bind cpu_8bit_alu_with_flags_unit c8alu_checker u_c8alu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.action      (action),
	.accumulator (accumulator),
	.flags_in    (flags_in),
	.done        (done),
	.result      (result),
	.flags_out   (flags_out),
	.write_back  (write_back)
);

FILE: dv/tb_cpu_8bit_alu_with_flags_unit.sv
module tb_cpu_8bit_alu_with_flags_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import c8alu_pkg::*;

	localparam int RANDOM_REQUESTS = 1400;
	localparam int STEADY_TAIL = 200;
	localparam int CYCLE_LIMIT = 200000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [4:0] action = '0;
	logic [7:0] accumulator = '0;
	logic [7:0] operand = '0;
	logic [2:0] bit_index = '0;
	logic [3:0] flags_in = '0;
	logic       done;
	logic [7:0] result;
	logic [3:0] flags_out;
	logic       write_back;
	int         cycles = 0;

	class alu_scoreboard;
		alu_res_t expected_q[$];
		int       mismatches = 0;

		function automatic alu_res_t alu_compute(logic [4:0] act, logic [7:0] a,
			logic [7:0] b, logic [2:0] bi, logic [3:0] f);
			alu_res_t   res;
			logic [8:0] full;
			logic [4:0] half;
			logic       c;
			logic       co;
			logic       msb;
			logic [7:0] r;
			logic [3:0] nf;
			logic       wb;
			r = a;
			nf = f;
			wb = 1'b1;
			case (op_t'(act))
				OP_ADD, OP_ADC: begin
					c = (act == OP_ADC) ? f[FLAG_C] : 1'b0;
					full = {1'b0, a} + {1'b0, b} + {8'd0, c};
					half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
					r = full[7:0];
					nf = {r == 8'h00, 1'b0, half[4], full[8]};
				end
				OP_SUB, OP_SBC, OP_CP: begin
					c = (act == OP_SBC) ? f[FLAG_C] : 1'b0;
					full = {1'b0, a} - {1'b0, b} - {8'd0, c};
					half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c};
					r = full[7:0];
					nf = {r == 8'h00, 1'b1, half[4], full[8]};
					if (act == OP_CP) begin
						r = a;
						wb = 1'b0;
					end
				end
				OP_AND: begin
					r = a & b;
					nf = {r == 8'h00, 1'b0, 1'b1, 1'b0};
				end
				OP_XOR: begin
					r = a ^ b;
					nf = {r == 8'h00, 3'b000};
				end
				OP_OR: begin
					r = a | b;
					nf = {r == 8'h00, 3'b000};
				end
				OP_INC: begin
					r = b + 8'd1;
					nf = {r == 8'h00, 1'b0, b[3:0] == 4'hf, f[FLAG_C]};
				end
				OP_DEC: begin
					r = b - 8'd1;
					nf = {r == 8'h00, 1'b1, b[3:0] == 4'h0, f[FLAG_C]};
				end
				OP_DAA: begin
					co = f[FLAG_C];
					if (!f[FLAG_N]) begin
						if (co || a > 8'h99) begin
							r = r + 8'h60;
							co = 1'b1;
						end
						if (f[FLAG_H] || a[3:0] > 4'h9)
							r = r + 8'h06;
					end else begin
						if (co)
							r = r - 8'h60;
						if (f[FLAG_H])
							r = r - 8'h06;
					end
					nf = {r == 8'h00, f[FLAG_N], 1'b0, co};
				end
				OP_CPL: begin
					r = ~a;
					nf = {f[FLAG_Z], 1'b1, 1'b1, f[FLAG_C]};
				end
				OP_RLC, OP_RL, OP_SLA: begin
					co = b[7];
					msb = (act == OP_RLC) ? b[7] : (act == OP_RL) ? f[FLAG_C] : 1'b0;
					r = {b[6:0], msb};
					nf = {r == 8'h00, 2'b00, co};
				end
				OP_RRC, OP_RR, OP_SRA, OP_SRL: begin
					co = b[0];
					case (op_t'(act))
						OP_RRC: msb = b[0];
						OP_RR: msb = f[FLAG_C];
						OP_SRA: msb = b[7];
						default: msb = 1'b0;
					endcase
					r = {msb, b[7:1]};
					nf = {r == 8'h00, 2'b00, co};
				end
				OP_SWAP: begin
					r = {b[3:0], b[7:4]};
					nf = {r == 8'h00, 3'b000};
				end
				OP_BIT: begin
					r = b;
					nf = {~b[bi], 1'b0, 1'b1, f[FLAG_C]};
					wb = 1'b0;
				end
				OP_RES: begin
					r = b;
					r[bi] = 1'b0;
				end
				OP_SET: begin
					r = b;
					r[bi] = 1'b1;
				end
				OP_CCF: begin
					nf = {f[FLAG_Z], 2'b00, ~f[FLAG_C]};
					wb = 1'b0;
				end
				OP_SCF: begin
					nf = {f[FLAG_Z], 2'b00, 1'b1};
					wb = 1'b0;
				end
				OP_RLCA, OP_RLA: begin
					r = {a[6:0], (act == OP_RLCA) ? a[7] : f[FLAG_C]};
					nf = {3'b000, a[7]};
				end
				OP_RRCA, OP_RRA: begin
					r = {(act == OP_RRCA) ? a[0] : f[FLAG_C], a[7:1]};
					nf = {3'b000, a[0]};
				end
				default: begin
					wb = 1'b0;
				end
			endcase
			res.result = r;
			res.flags = nf;
			res.write_back = wb;
			return res;
		endfunction

		function void note_request(logic [4:0] act, logic [7:0] a, logic [7:0] b,
			logic [2:0] bi, logic [3:0] f);
			expected_q.push_back(alu_compute(act, a, b, bi, f));
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(logic [7:0] r, logic [3:0] fl, logic wb);
			alu_res_t exp_res;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result %02h flags %h wb %b", r, fl, wb));
			end else begin
				exp_res = expected_q.pop_front();
				if (r !== exp_res.result)
					report($sformatf("result %02h, expected %02h", r, exp_res.result));
				if (fl !== exp_res.flags)
					report($sformatf("flags %h, expected %h", fl, exp_res.flags));
				if (wb !== exp_res.write_back)
					report($sformatf("write_back %b, expected %b", wb, exp_res.write_back));
			end
		endtask
	endclass

	alu_scoreboard sb = new();

	cpu_8bit_alu_with_flags_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.accumulator(accumulator),
		.operand(operand),
		.bit_index(bit_index),
		.flags_in(flags_in),
		.done(done),
		.result(result),
		.flags_out(flags_out),
		.write_back(write_back)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout with %0d results outstanding.", sb.expected_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result, flags_out, write_back);
			if (start && !busy)
				sb.note_request(action, accumulator, operand, bit_index, flags_in);
		end
	end

	task automatic send_request(logic [4:0] act, logic [7:0] a, logic [7:0] b,
		logic [2:0] bi, logic [3:0] f, bit allow_gap);
		action <= act;
		accumulator <= a;
		operand <= b;
		bit_index <= bi;
		flags_in <= f;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 11))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h0f;
			3: return 8'hf0;
			4: return 8'h99;
			5: return 8'h80;
			6: return 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		logic [4:0] act;
		logic [7:0] a;
		logic [7:0] b;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k <= int'(OP_RRA); k++) begin
			a = k[0] ? 8'hff : 8'h9a;
			b = (k % 3 == 0) ? 8'h01 : (k % 3 == 1) ? 8'hff : 8'h00;
			send_request(5'(k), a, b, 3'(k), 4'(k), 1'b1);
		end
		send_request(5'd31, 8'h5a, 8'ha5, 3'd7, 4'hf, 1'b1);
		send_request(OP_DAA, 8'h9a, 8'h00, 3'd0, 4'h0, 1'b1);
		send_request(OP_DAA, 8'h00, 8'h00, 3'd0,
			4'((1 << FLAG_N) | (1 << FLAG_H) | (1 << FLAG_C)), 1'b1);
		send_request(OP_SBC, 8'h00, 8'hff, 3'd0, 4'(1 << FLAG_C), 1'b1);
		send_request(OP_ADC, 8'hff, 8'h00, 3'd0, 4'(1 << FLAG_C), 1'b1);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if ($urandom_range(0, 19) == 0)
				act = 5'($urandom_range(int'(OP_RRA) + 1, 31));
			else
				act = 5'($urandom_range(int'(OP_ADD), int'(OP_RRA)));
			a = pick_byte();
			b = pick_byte();
			send_request(act, a, b, 3'($urandom), 4'($urandom),
				n < RANDOM_REQUESTS - STEADY_TAIL);
		end
		start <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

FILE: cpu_8bit_alu_with_flags_unit.f
rtl/c8alu_pkg.sv
rtl/c8alu_exec.sv
rtl/cpu_8bit_alu_with_flags_unit.sv
rtl/c8alu_checker.sv
dv/tb_cpu_8bit_alu_with_flags_unit.sv
